// ===== sv/cpr_pkg.sv =====
// Shared types and constants of the clock page replacement block.
// No dependencies; used by the page table and the top level.
package cpr_pkg;

    localparam int VPN_W   = 8;
    localparam int PFN_W   = 4;
    localparam int NPAGES  = 1 << VPN_W;
    localparam int NFRAMES = 1 << PFN_W;

    localparam logic [1:0] CMD_FAULT = 2'd0;
    localparam logic [1:0] CMD_MAP   = 2'd1;
    localparam logic [1:0] CMD_UNMAP = 2'd2;
    localparam logic [1:0] CMD_REF   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             referenced;
        logic             dirty;
        logic             allocated;
        logic [PFN_W-1:0] frame;
    } pte_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [VPN_W-1:0] page;
        logic             is_write;
    } in_t;

    typedef struct packed {
        logic             status;
        logic [PFN_W-1:0] frame;
        logic             loaded;
        logic             created;
        logic             evicted_valid;
        logic [VPN_W-1:0] evicted_page;
        logic             writeback;
        logic             deleted;
        logic [VPN_W-1:0] reply_page;
    } out_t;

endpackage

// ===== sv/cpr_page_table.sv =====
// Page table memory: one entry per virtual page, one read and one write port.
// Depends on cpr_pkg; entries never written read as all zero.
module cpr_page_table (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [cpr_pkg::VPN_W-1:0]  rd_addr,
    output cpr_pkg::pte_t              rd_data,
    input  logic                       wr_en,
    input  logic [cpr_pkg::VPN_W-1:0]  wr_addr,
    input  cpr_pkg::pte_t              wr_data
);

    cpr_pkg::pte_t                mem [cpr_pkg::NPAGES];
    logic [cpr_pkg::NPAGES-1:0]   written_reg;
    cpr_pkg::pte_t                q_reg;
    logic                         q_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            q_ok_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                q_ok_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_ok_reg ? q_reg : '0;

endmodule

// ===== sv/clock_page_replacement.sv =====
// Clock (second-chance) page-fault manager. One command is handled at a time.
// Map, unmap, reference reports and faults on resident or illegal pages go
// from the page table read straight to the result; a fault that fills an empty
// frame rereads and writes the page table first; a fault that sweeps also reads
// and writes back the page table for each frame the hand visits (at most
// NFRAMES+1). The next command is taken in the cycle the result goes valid.
// Depends on cpr_pkg and cpr_page_table.
module clock_page_replacement (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [8:0]    cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  cpr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cpr_pkg::out_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_SW_IS = 3'd2;
    localparam logic [2:0] ST_SW_RD = 3'd3;
    localparam logic [2:0] ST_F_IS  = 3'd4;
    localparam logic [2:0] ST_F_RD  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam int PB = cpr_pkg::VPN_W;
    localparam int FB = cpr_pkg::PFN_W;

    logic [2:0]              state_reg, state_next;
    logic [8:0]              init_reg;
    cpr_pkg::in_t            item_reg, item_next;
    cpr_pkg::out_t           res_reg, res_next;
    cpr_pkg::out_t           out_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [FB-1:0]           hand_reg, hand_next;
    logic [FB-1:0]           target_reg, target_next;
    logic [PB-1:0]           vic_reg, vic_next;
    logic [PB-1:0]           owner_reg [cpr_pkg::NFRAMES];
    logic [cpr_pkg::NFRAMES-1:0] empty_reg;
    logic                    own_we;

    logic                    rd_en;
    logic [PB-1:0]           rd_addr;
    cpr_pkg::pte_t           e;
    logic                    wr_en;
    cpr_pkg::pte_t           wr_data;
    logic [PB-1:0]           wr_addr;
    logic                    any_empty;
    logic [FB-1:0]           first_empty;
    logic                    accept;

    cpr_page_table u_pt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (e),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        any_empty   = |empty_reg;
        first_empty = '0;
        for (int i = cpr_pkg::NFRAMES - 1; i >= 0; i--) begin
            if (empty_reg[i]) begin
                first_empty = FB'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        hand_next    = hand_reg;
        target_next  = target_reg;
        vic_next     = vic_reg;
        m_valid_next = m_valid_reg;
        rd_en        = 1'b0;
        rd_addr      = item_reg.page;
        wr_en        = 1'b0;
        wr_addr      = item_reg.page;
        wr_data      = e;
        own_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_data;
                    res_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = s_data.page;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_DONE;
                case (item_reg.cmd)
                    cpr_pkg::CMD_FAULT: begin
                        if ({1'b0, item_reg.page} >= init_reg && !e.allocated) begin
                            res_next.status = 1'b1;
                        end else if (e.valid) begin
                            res_next.frame = e.frame;
                        end else if (any_empty) begin
                            target_next = first_empty;
                            state_next  = ST_F_IS;
                        end else begin
                            state_next = ST_SW_IS;
                        end
                    end
                    cpr_pkg::CMD_MAP: begin
                        wr_en              = 1'b1;
                        wr_data.allocated  = 1'b1;
                        res_next.created   = 1'b1;
                        res_next.reply_page = item_reg.page;
                    end
                    cpr_pkg::CMD_UNMAP: begin
                        if (e.allocated) begin
                            wr_en             = 1'b1;
                            wr_data.valid     = 1'b0;
                            wr_data.allocated = 1'b0;
                            res_next.deleted  = 1'b1;
                        end
                    end
                    default: begin
                        if (e.valid) begin
                            wr_en              = 1'b1;
                            wr_data.referenced = 1'b1;
                            wr_data.dirty      = e.dirty | item_reg.is_write;
                        end
                    end
                endcase
            end
            ST_SW_IS: begin
                vic_next   = owner_reg[hand_reg];
                rd_en      = 1'b1;
                rd_addr    = owner_reg[hand_reg];
                state_next = ST_SW_RD;
            end
            ST_SW_RD: begin
                wr_en   = 1'b1;
                wr_addr = vic_reg;
                if (e.referenced) begin
                    // second chance: clear and advance
                    wr_data.referenced = 1'b0;
                    hand_next  = hand_reg + 1'b1;
                    state_next = ST_SW_IS;
                end else begin
                    wr_data.dirty = 1'b0;
                    wr_data.valid = e.valid && (e.frame != hand_reg);
                    res_next.evicted_valid = 1'b1;
                    res_next.evicted_page  = vic_reg;
                    res_next.writeback     = e.dirty;
                    target_next = hand_reg;
                    hand_next   = hand_reg + 1'b1;
                    state_next  = ST_F_IS;
                end
            end
            ST_F_IS: begin
                // reread: the victim write may have touched this page
                rd_en      = 1'b1;
                state_next = ST_F_RD;
            end
            ST_F_RD: begin
                wr_en             = 1'b1;
                wr_data.valid     = 1'b1;
                wr_data.allocated = 1'b1;
                wr_data.frame     = target_reg;
                own_we            = 1'b1;
                res_next.created  = !e.allocated;
                res_next.loaded   = 1'b1;
                res_next.frame    = target_reg;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            hand_reg    <= '0;
            empty_reg   <= '1;
            init_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            hand_reg    <= hand_next;
            if (own_we) begin
                empty_reg[target_reg] <= 1'b0;
            end
            if (cfg_wr_en) begin
                init_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        target_reg <= target_next;
        vic_reg    <= vic_next;
        if (own_we) begin
            owner_reg[target_reg] <= item_reg.page;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_reg <= res_reg;
        end
    end

`ifndef ASSERT_OFF
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_RD)
        else $error("transfer in did not start a page table read");
    a_hand_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        hand_reg != $past(hand_reg) |-> $past(state_reg) == ST_SW_RD)
        else $error("clock hand moved outside the sweep");
    a_victim_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SW_RD && !e.referenced |=> state_reg == ST_F_IS)
        else $error("victim chosen but no fill followed");
    a_fill_clears_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        own_we |=> !empty_reg[$past(target_reg)])
        else $error("filled frame still marked empty");
`endif

endmodule
